>>> rtl/brsd_pkg.sv
// Shared types and constants for the bilevel run-length span decoder.
// No dependencies; imported by bilevel_rle_span_decoder and the testbench.
package brsd_pkg;

    localparam int OUT_IDX_BITS = 20;
    localparam int COLOR_BITS   = 16;
    localparam int CFG_DATA_BITS = 20;
    localparam int CFG_IDX_BITS  = 2;
    localparam int RUN_BITS      = 32;

    typedef logic [2:0] t_status;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_status ST_OK          = 3'd0;
    localparam t_status ST_TOO_SHORT   = 3'd1;
    localparam t_status ST_ZERO_RUN    = 3'd2;
    localparam t_status ST_OVERLONG    = 3'd3;
    localparam t_status ST_TRUNCATED   = 3'd4;
    localparam t_status ST_NOT_FILLED  = 3'd5;

    localparam t_cfg_idx CFG_FRAME_PIXELS = 2'd0;
    localparam t_cfg_idx CFG_ON_COLOR     = 2'd1;
    localparam t_cfg_idx CFG_OFF_COLOR    = 2'd2;

    // LEB128 layout
    localparam logic [7:0] VARINT_MORE = 8'h80;
    localparam logic [2:0] VARINT_LAST_GROUP = 3'd4;

    localparam logic [31:0] FRAME_PIXELS_RESET = 32'd57600;
    localparam logic [15:0] ON_COLOR_RESET     = 16'hFFFF;
    localparam logic [15:0] OFF_COLOR_RESET    = 16'h0000;

endpackage

>>> rtl/bilevel_rle_span_decoder.sv
// Top level of the bilevel run-length span decoder: byte input register,
// single-pass span decode and result register. Depends on brsd_pkg.
//
// Decodes one compressed bilevel frame, one byte per word: a color byte
// (nonzero starts on the on color), then LEB128 run lengths of up to five
// bytes, each producing a span (start pixel, length clipped to the frame,
// RGB565 color) with the color alternating. The word flagged last closes
// the frame and carries its status (ok, too short, zero run, overlong
// varint, truncated varint, not filled), together with a span completed on
// that byte. The block takes one word per clock, except while a word with
// a result waits on a full, stalled result register; a word is loaded into
// the input register and its decode into the result register. The decode step
// is combinational: varint accumulate, clip compare and position add sit
// between the input and result registers. Words that yield no result
// (continuation bytes, ignored bytes) update state and never wait on the
// output side. Configuration must be written while the block is idle, which
// it does not enforce; frame_pixels is taken modulo 2**PIXEL_INDEX_BITS.
module bilevel_rle_span_decoder #(
    parameter int PIXEL_INDEX_BITS = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  brsd_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [brsd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    // byte input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_data_byte,
    input  logic                                i_last_byte,
    // span result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_span_valid,
    output logic [brsd_pkg::OUT_IDX_BITS-1:0]   o_span_start,
    output logic [brsd_pkg::OUT_IDX_BITS-1:0]   o_span_length,
    output logic [brsd_pkg::COLOR_BITS-1:0]     o_pixel_value,
    output logic                                o_frame_end,
    output brsd_pkg::t_status                   o_frame_status
);
    import brsd_pkg::*;

    localparam int PB = PIXEL_INDEX_BITS;

    // configuration registers
    logic [PB-1:0]         r_frame_pixels;
    logic [COLOR_BITS-1:0] r_on_color;
    logic [COLOR_BITS-1:0] r_off_color;
    logic [31:0]           cfg_wide;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // frame state
    logic [PB-1:0]       r_pos,    n_pos;
    logic                r_color,  n_color;
    logic [RUN_BITS-1:0] r_acc,    n_acc;
    logic [2:0]          r_shift,  n_shift;
    logic                r_header, n_header;
    t_status             r_err,    n_err;
    logic                r_full,   n_full;

    // result register
    logic                    r_out_valid;
    logic                    r_span_valid, n_span_valid;
    logic [PB-1:0]           r_span_start, n_span_start;
    logic [PB-1:0]           r_span_len,   n_span_len;
    logic [COLOR_BITS-1:0]   r_pix,        n_pix;
    logic                    r_end;
    t_status                 r_status,     n_status;

    // decode datapath
    logic                full_now;
    logic [RUN_BITS-1:0] group_bits;
    logic [RUN_BITS-1:0] acc_or;
    logic [PB-1:0]       remain;
    logic [PB-1:0]       run_len;
    logic [PB-1:0]       pos_add;
    logic                want_result;
    logic                out_free;
    logic                process;
    logic [31:0]         start_wide;
    logic [31:0]         len_wide;

    assign cfg_wide = 32'(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_pixels <= FRAME_PIXELS_RESET[PB-1:0];
            r_on_color     <= ON_COLOR_RESET;
            r_off_color    <= OFF_COLOR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_PIXELS: r_frame_pixels <= cfg_wide[PB-1:0];
                CFG_ON_COLOR:     r_on_color     <= i_cfg_data[COLOR_BITS-1:0];
                CFG_OFF_COLOR:    r_off_color    <= i_cfg_data[COLOR_BITS-1:0];
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    // Place the 7-bit group at its LEB128 offset; the fifth group loses
    // its top three bits to the 32-bit truncation.
    always_comb begin
        case (r_shift)
            3'd0:    group_bits = {25'd0, r_in_byte[6:0]};
            3'd1:    group_bits = {18'd0, r_in_byte[6:0], 7'd0};
            3'd2:    group_bits = {11'd0, r_in_byte[6:0], 14'd0};
            3'd3:    group_bits = {4'd0, r_in_byte[6:0], 21'd0};
            default: group_bits = {r_in_byte[3:0], 28'd0};
        endcase
    end

    assign full_now = r_full || (r_pos >= r_frame_pixels);
    assign acc_or   = r_acc | group_bits;
    assign remain   = r_frame_pixels - r_pos;
    assign run_len  = (acc_or < 32'(remain)) ? acc_or[PB-1:0] : remain;
    assign pos_add  = r_pos + run_len;

    always_comb begin
        n_pos        = r_pos;
        n_color      = r_color;
        n_acc        = r_acc;
        n_shift      = r_shift;
        n_header     = r_header;
        n_err        = r_err;
        n_full       = r_full;
        n_span_valid = 1'b0;
        n_span_start = '0;
        n_span_len   = '0;
        n_pix        = '0;
        n_status     = ST_OK;

        if (!r_header) begin
            // color byte opens the frame
            n_header = 1'b1;
            n_color  = (r_in_byte != 8'd0);
            if (r_in_last) begin
                n_status = ST_TOO_SHORT;
            end
        end else if (r_err == ST_OK && !full_now) begin
            n_acc = acc_or;
            if ((r_in_byte & VARINT_MORE) != 8'd0) begin
                if (r_shift >= VARINT_LAST_GROUP) begin
                    n_err = ST_OVERLONG;
                end else if (r_in_last) begin
                    n_err = ST_TRUNCATED;
                end else begin
                    n_shift = r_shift + 3'd1;
                end
            end else if (acc_or == '0) begin
                n_err = ST_ZERO_RUN;
            end else begin
                // run complete: emit the clipped span and flip color
                n_span_valid = 1'b1;
                n_span_start = r_pos;
                n_span_len   = run_len;
                n_pix        = r_color ? r_on_color : r_off_color;
                n_pos        = pos_add;
                n_full       = r_full || (pos_add >= r_frame_pixels);
                n_color      = ~r_color;
                n_acc        = '0;
                n_shift      = 3'd0;
            end
            if (r_in_last) begin
                if (n_err != ST_OK) begin
                    n_status = n_err;
                end else if (n_full || (n_pos >= r_frame_pixels)) begin
                    n_status = ST_OK;
                end else begin
                    n_status = ST_NOT_FILLED;
                end
            end
        end else if (r_in_last) begin
            n_status = r_err;
        end
    end

    // A word without a result never waits for the output side.
    assign want_result = n_span_valid || r_in_last;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign process     = r_in_valid && (out_free || !want_result);
    assign o_in_stall  = r_in_valid && !process;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // frame state: advance on each decoded word, clear at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_color  <= 1'b0;
            r_acc    <= '0;
            r_shift  <= 3'd0;
            r_header <= 1'b0;
            r_err    <= ST_OK;
            r_full   <= 1'b0;
        end else if (process) begin
            if (r_in_last) begin
                r_pos    <= '0;
                r_color  <= 1'b0;
                r_acc    <= '0;
                r_shift  <= 3'd0;
                r_header <= 1'b0;
                r_err    <= ST_OK;
                r_full   <= 1'b0;
            end else begin
                r_pos    <= n_pos;
                r_color  <= n_color;
                r_acc    <= n_acc;
                r_shift  <= n_shift;
                r_header <= n_header;
                r_err    <= n_err;
                r_full   <= n_full;
            end
        end
    end

    // result register: load a new word or drop the one taken downstream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process && want_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && want_result) begin
            r_span_valid <= n_span_valid;
            r_span_start <= n_span_start;
            r_span_len   <= n_span_len;
            r_pix        <= n_pix;
            r_end        <= r_in_last;
            r_status     <= n_status;
        end
    end

    assign start_wide     = 32'(r_span_start);
    assign len_wide       = 32'(r_span_len);
    assign o_out_valid    = r_out_valid;
    assign o_span_valid   = r_span_valid;
    assign o_span_start   = start_wide[OUT_IDX_BITS-1:0];
    assign o_span_length  = len_wide[OUT_IDX_BITS-1:0];
    assign o_pixel_value  = r_pix;
    assign o_frame_end    = r_end;
    assign o_frame_status = r_status;

    // a span that closes a frame can only come with ok or not filled
    a_span_end_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_end && r_span_valid) |->
            (r_status == ST_OK || r_status == ST_NOT_FILLED))
        else $error("span closed a frame with an error status");

    // a span always covers at least one pixel
    a_span_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_span_valid) |-> (r_span_len != '0))
        else $error("zero-length span reported");

    // results that are not spans carry a zero payload and always close a frame
    a_empty_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_span_valid) |->
            (r_span_start == '0 && r_span_len == '0 && r_pix == '0 && r_end))
        else $error("result without span is malformed");

    // frame state is cleared after the closing word
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && r_in_last) |=> (r_pos == '0 && !r_header && r_err == ST_OK))
        else $error("frame state not cleared at frame end");

    // input side only stalls with a word held that cannot move on
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for bilevel_rle_span_decoder: a directed script, then random frames.
// A predictor in this file supplies the expected span words, except for script rows that carry their own.
// Depends on brsd_pkg and the decoder RTL.
module testbench;
    import brsd_pkg::*;

    localparam int          SETTLE_CYCLES = 6;      // two-stage pipeline plus margin
    localparam int          PHASE_BYTES   = 640;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic                    span_valid;
        logic [OUT_IDX_BITS-1:0] span_start;
        logic [OUT_IDX_BITS-1:0] span_length;
        logic [COLOR_BITS-1:0]   pixel_value;
        logic                    frame_end;
        t_status                 frame_status;
    } t_span_word;

    typedef enum logic [1:0] {ROW_BYTE, ROW_LAST, ROW_CFG} t_row_kind;

    // One script row: a data byte, a closing byte, or a register write.
    typedef struct packed {
        t_row_kind                kind;
        logic [CFG_DATA_BITS-1:0] arg;
        t_cfg_idx                 reg_idx;
        logic                     typed;
        t_span_word               want;
    } t_script_row;

    localparam t_span_word NO_WORD = '0;
    localparam int         NUM_ROWS = 31;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    t_cfg_idx                 i_cfg_index = CFG_FRAME_PIXELS;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [7:0]               i_data_byte = 8'h00;
    logic                     i_last_byte = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic                     o_span_valid;
    logic [OUT_IDX_BITS-1:0]  o_span_start;
    logic [OUT_IDX_BITS-1:0]  o_span_length;
    logic [COLOR_BITS-1:0]    o_pixel_value;
    logic                     o_frame_end;
    t_status                  o_frame_status;

    // Predictor copy of the registers and the frame state
    logic [OUT_IDX_BITS-1:0]  frame_px;
    logic [COLOR_BITS-1:0]    on_rgb;
    logic [COLOR_BITS-1:0]    off_rgb;
    logic [OUT_IDX_BITS:0]    pen_pos = '0;
    logic                     pen_on = 1'b0;
    logic [RUN_BITS-1:0]      run_acc = '0;
    logic [2:0]               run_groups = '0;
    logic                     hdr_seen = 1'b0;
    t_status                  frame_err = ST_OK;
    logic                     frame_done = 1'b0;

    t_span_word  pending_spans[$];
    int          mismatches = 0;
    int          phase_bytes = 0;
    int          send_idle_pct = 9;
    int          recv_idle_pct = 73;
    int unsigned cycle_count;

    // Directed script: reset colors first, then the extremes of every register.
    t_script_row script [NUM_ROWS] = '{
        // plain frame: off color, two-byte run, closes before the frame is full
        '{ROW_BYTE, 20'h00, CFG_FRAME_PIXELS, 1'b0, NO_WORD},
        '{ROW_BYTE, 20'hff, CFG_FRAME_PIXELS, 1'b0, NO_WORD},
        '{ROW_LAST, 20'h7f, CFG_FRAME_PIXELS, 1'b1,
          '{1'b1, 20'd0, 20'd16383, 16'h0000, 1'b1, ST_NOT_FILLED}},
        // header byte closes the frame
        '{ROW_LAST, 20'h01, CFG_FRAME_PIXELS, 1'b1,
          '{1'b0, 20'd0, 20'd0, 16'h0000, 1'b1, ST_TOO_SHORT}},
        // padded zero run, then a byte dropped under the latched error
        '{ROW_BYTE, 20'h01, CFG_FRAME_PIXELS, 1'b0, NO_WORD},
        '{ROW_BYTE, 20'h80, CFG_FRAME_PIXELS, 1'b0, NO_WORD},
        '{ROW_BYTE, 20'h00, CFG_FRAME_PIXELS, 1'b0, NO_WORD},
        '{ROW_LAST, 20'h10, CFG_FRAME_PIXELS, 1'b1,
          '{1'b0, 20'd0, 20'd0, 16'h0000, 1'b1, ST_ZERO_RUN}},
        // fifth byte still continues and is last: overlong wins over truncated
        '{ROW_BYTE, 20'hff, CFG_FRAME_PIXELS, 1'b0, NO_WORD},
        '{ROW_BYTE, 20'hff, CFG_FRAME_PIXELS, 1'b0, NO_WORD},
        '{ROW_BYTE, 20'hff, CFG_FRAME_PIXELS, 1'b0, NO_WORD},
        '{ROW_BYTE, 20'hff, CFG_FRAME_PIXELS, 1'b0, NO_WORD},
        '{ROW_BYTE, 20'hff, CFG_FRAME_PIXELS, 1'b0, NO_WORD},
        '{ROW_LAST, 20'h8f, CFG_FRAME_PIXELS, 1'b1,
          '{1'b0, 20'd0, 20'd0, 16'h0000, 1'b1, ST_OVERLONG}},
        // frame ends inside a varint
        '{ROW_BYTE, 20'h00, CFG_FRAME_PIXELS, 1'b0, NO_WORD},
        '{ROW_LAST, 20'h81, CFG_FRAME_PIXELS, 1'b1,
          '{1'b0, 20'd0, 20'd0, 16'h0000, 1'b1, ST_TRUNCATED}},
        // one-pixel frame, swapped color extremes
        '{ROW_CFG, 20'd1, CFG_FRAME_PIXELS, 1'b0, NO_WORD},
        '{ROW_CFG, 20'h00000, CFG_ON_COLOR, 1'b0, NO_WORD},
        '{ROW_CFG, 20'h0ffff, CFG_OFF_COLOR, 1'b0, NO_WORD},
        // five-byte run of 2**32-1 clipped to one pixel, then a dropped byte closes ok
        '{ROW_BYTE, 20'h02, CFG_FRAME_PIXELS, 1'b0, NO_WORD},
        '{ROW_BYTE, 20'hff, CFG_FRAME_PIXELS, 1'b0, NO_WORD},
        '{ROW_BYTE, 20'hff, CFG_FRAME_PIXELS, 1'b0, NO_WORD},
        '{ROW_BYTE, 20'hff, CFG_FRAME_PIXELS, 1'b0, NO_WORD},
        '{ROW_BYTE, 20'hff, CFG_FRAME_PIXELS, 1'b0, NO_WORD},
        '{ROW_BYTE, 20'h0f, CFG_FRAME_PIXELS, 1'b1,
          '{1'b1, 20'd0, 20'd1, 16'h0000, 1'b0, ST_OK}},
        '{ROW_LAST, 20'h81, CFG_FRAME_PIXELS, 1'b1,
          '{1'b0, 20'd0, 20'd0, 16'h0000, 1'b1, ST_OK}},
        // largest frame; mid-frame rewrite to zero pixels marks it full
        '{ROW_CFG, 20'hfffff, CFG_FRAME_PIXELS, 1'b0, NO_WORD},
        '{ROW_BYTE, 20'h00, CFG_FRAME_PIXELS, 1'b0, NO_WORD},
        '{ROW_BYTE, 20'h0a, CFG_FRAME_PIXELS, 1'b1,
          '{1'b1, 20'd0, 20'd10, 16'hffff, 1'b0, ST_OK}},
        '{ROW_CFG, 20'd0, CFG_FRAME_PIXELS, 1'b0, NO_WORD},
        '{ROW_LAST, 20'h03, CFG_FRAME_PIXELS, 1'b1,
          '{1'b0, 20'd0, 20'd0, 16'h0000, 1'b1, ST_OK}}
    };

    bilevel_rle_span_decoder u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_span_valid   (o_span_valid),
        .o_span_start   (o_span_start),
        .o_span_length  (o_span_length),
        .o_pixel_value  (o_pixel_value),
        .o_frame_end    (o_frame_end),
        .o_frame_status (o_frame_status)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Decode one accepted byte; return 1 when it yields a span word.
    function automatic bit decode_byte(input logic [7:0] data, input logic last,
                                       output t_span_word res);
        logic [OUT_IDX_BITS:0] remain;
        logic [RUN_BITS-1:0]   len;
        logic                  full;
        t_status               status;

        res = '0;
        status = ST_OK;
        full = frame_done || (pen_pos >= {1'b0, frame_px});
        if (!hdr_seen) begin
            hdr_seen = 1'b1;
            pen_on = (data != 8'h00);
            if (last) begin
                status = ST_TOO_SHORT;
            end
        end else if (frame_err == ST_OK && !full) begin
            run_acc = run_acc | (RUN_BITS'(data[6:0]) << (7 * int'(run_groups)));
            if ((data & VARINT_MORE) != 8'h00) begin
                if (run_groups >= VARINT_LAST_GROUP) begin
                    frame_err = ST_OVERLONG;
                end else if (last) begin
                    frame_err = ST_TRUNCATED;
                end else begin
                    run_groups = run_groups + 3'd1;
                end
            end else if (run_acc == '0) begin
                frame_err = ST_ZERO_RUN;
            end else begin
                // clip the run to what is left of the frame
                remain = {1'b0, frame_px} - pen_pos;
                len = (run_acc < RUN_BITS'(remain)) ? run_acc : RUN_BITS'(remain);
                res.span_valid = 1'b1;
                res.span_start = pen_pos[OUT_IDX_BITS-1:0];
                res.span_length = len[OUT_IDX_BITS-1:0];
                res.pixel_value = pen_on ? on_rgb : off_rgb;
                pen_pos = pen_pos + len[OUT_IDX_BITS:0];
                if (pen_pos >= {1'b0, frame_px}) begin
                    frame_done = 1'b1;
                end
                pen_on = ~pen_on;
                run_acc = '0;
                run_groups = '0;
            end
            if (last) begin
                if (frame_err != ST_OK) begin
                    status = frame_err;
                end else begin
                    full = frame_done || (pen_pos >= {1'b0, frame_px});
                    status = full ? ST_OK : ST_NOT_FILLED;
                end
            end
        end else if (last) begin
            status = frame_err;
        end

        if (last) begin
            res.frame_end = 1'b1;
            res.frame_status = status;
            pen_pos = '0;
            pen_on = 1'b0;
            run_acc = '0;
            run_groups = '0;
            hdr_seen = 1'b0;
            frame_err = ST_OK;
            frame_done = 1'b0;
        end
        return res.span_valid || last;
    endfunction

    // Offer one byte, idling at random first; record the expected word once accepted.
    task automatic put_byte(input logic [7:0] data, input logic last,
                            input logic typed, input t_span_word want);
        t_span_word got;
        bit         produced;

        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= data;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        produced = decode_byte(data, last, got);
        if (typed) begin
            pending_spans.push_back(want);
        end else if (produced) begin
            pending_spans.push_back(got);
        end
    endtask

    // Drain every outstanding word, let the pipeline settle, then write one register.
    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] value);
        i_in_valid <= 1'b0;
        while (pending_spans.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FRAME_PIXELS: frame_px = value;
            CFG_ON_COLOR:     on_rgb = value[COLOR_BITS-1:0];
            CFG_OFF_COLOR:    off_rgb = value[COLOR_BITS-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Pick a new frame size and colors; small frames dominate.
    task automatic retune();
        logic [CFG_DATA_BITS-1:0] px;

        case ($urandom_range(0, 9))
            0:       px = 20'd1;
            1:       px = 20'hfffff;
            2, 3:    px = 20'($urandom_range(201, 5000));
            default: px = 20'($urandom_range(1, 200));
        endcase
        cfg_write(CFG_FRAME_PIXELS, px);
        cfg_write(CFG_ON_COLOR, 20'($urandom_range(0, 65535)));
        cfg_write(CFG_OFF_COLOR, 20'($urandom_range(0, 65535)));
    endtask

    // Build one frame: mostly well-formed runs, otherwise early end, a zero run or a broken varint.
    task automatic send_random_frame();
        logic [7:0]  frame_q[$];
        logic [7:0]  chunk;
        int unsigned left;
        int unsigned run;
        int unsigned val;
        int unsigned groups;
        int unsigned runs_max;
        int unsigned flavor;
        bit          pad;
        bit          done;

        flavor = $urandom_range(0, 99);
        frame_q.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
        left = 32'(frame_px);
        runs_max = (flavor < 55) ? 24 : $urandom_range(0, 5);
        if (flavor >= 95) begin
            runs_max = 0;
        end
        for (int r = 0; r < runs_max && left != 0; r++) begin
            case ($urandom_range(0, 9))
                0:       run = $urandom;
                1:       run = left;
                2:       run = left + $urandom_range(1, 100);
                default: run = $urandom_range(1, (left < 64) ? left : left / 3);
            endcase
            if (run == 0) begin
                run = 1;
            end
            // broken frames must not fill up, or the fault would be dropped
            if (flavor >= 55 && run >= left) begin
                if (left == 1) begin
                    break;
                end
                run = $urandom_range(1, left - 1);
            end
            left = (run >= left) ? 0 : left - run;
            // LEB128, sometimes padded with empty groups up to five bytes
            val = run;
            groups = 0;
            pad = ($urandom_range(0, 7) == 0);
            done = 1'b0;
            while (!done) begin
                chunk = 8'(val & 32'h7f);
                val = val >> 7;
                groups++;
                if (groups == 5) begin
                    chunk = chunk | 8'($urandom_range(0, 7) << 4);  // bits past 32 drop
                end
                if (val == 0 && !(pad && groups < 5 && $urandom_range(0, 1) == 1)) begin
                    frame_q.push_back(chunk);
                    done = 1'b1;
                end else begin
                    frame_q.push_back(chunk | VARINT_MORE);
                end
            end
        end

        if (flavor < 55) begin
            if (left == 0 && $urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
            end
        end else if (flavor >= 67 && flavor < 77) begin
            repeat ($urandom_range(0, 3)) frame_q.push_back(VARINT_MORE);
            frame_q.push_back(8'h00);
            repeat ($urandom_range(0, 2)) frame_q.push_back(8'($urandom));
        end else if (flavor >= 77 && flavor < 86) begin
            repeat (5) frame_q.push_back(8'($urandom) | VARINT_MORE);
            repeat ($urandom_range(0, 2)) frame_q.push_back(8'($urandom));
        end else if (flavor >= 86 && flavor < 95) begin
            repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom) | VARINT_MORE);
        end

        foreach (frame_q[i]) begin
            put_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, NO_WORD);
        end
        phase_bytes += frame_q.size();
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned seen);
        if (want != seen) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            mismatches++;
        end
    endtask

    // Receiver back-pressure, independent of the valid line
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Compare each accepted span word with the oldest expectation.
    always @(posedge i_clk) begin : span_monitor
        t_span_word head;

        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_spans.size() == 0) begin
                $error("span word arrived with nothing expected");
                mismatches++;
            end else begin
                head = pending_spans.pop_front();
                check_field("span_valid", 32'(head.span_valid), 32'(o_span_valid));
                check_field("span_start", 32'(head.span_start), 32'(o_span_start));
                check_field("span_length", 32'(head.span_length), 32'(o_span_length));
                check_field("pixel_value", 32'(head.pixel_value), 32'(o_pixel_value));
                check_field("frame_end", 32'(head.frame_end), 32'(o_frame_end));
                check_field("frame_status", 32'(head.frame_status), 32'(o_frame_status));
            end
        end
    end

    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) begin
            @(posedge i_clk);
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        frame_px = FRAME_PIXELS_RESET[OUT_IDX_BITS-1:0];
        on_rgb = ON_COLOR_RESET;
        off_rgb = OFF_COLOR_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[n]) begin
            if (script[n].kind == ROW_CFG) begin
                cfg_write(script[n].reg_idx, script[n].arg);
            end else begin
                put_byte(script[n].arg[7:0], script[n].kind == ROW_LAST,
                         script[n].typed, script[n].want);
            end
        end

        // Idle mix per phase: slow receiver, then slow sender, then full rate.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 73 : 0;
            recv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 9 : 0;
            retune();
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                if ($urandom_range(0, 3) == 0) begin
                    retune();
                end
                send_random_frame();
            end
        end

        i_in_valid <= 1'b0;
        while (pending_spans.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_spans.size() != 0) begin
            $error("%0d expected span words never arrived", pending_spans.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
